@@ hw/rtl/frdf_pkg.sv @@
// Package with the shared constants and types of the flood relay duplicate filter.
package frdf_pkg;

  localparam int CACHE_DEPTH_DEF = 20;

  localparam int KEY_W   = 64;
  localparam int SRC_W   = 16;
  localparam int SEQ_W   = 32;
  localparam int HOPS_W  = 8;
  localparam int ACT_W   = 2;
  localparam int ENTRY_W = SRC_W + SEQ_W;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_INVALID   = 2'd0;
  localparam action_t ACT_DUPLICATE = 2'd1;
  localparam action_t ACT_FORWARD   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

@@ hw/rtl/frdf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module frdf_ram #(
  parameter int WIDTH = frdf_pkg::ENTRY_W,
  parameter int DEPTH = frdf_pkg::CACHE_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/flood_relay_duplicate_filter.sv @@
// Top level of the flood relay duplicate filter: header check, cache scan and update.
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   ----------------------------------------------
//   config    cfg_we                     cfg_wdata (expected key)
//   input     start high while busy low  in_length_ok, in_packet_key, in_source_id,
//                                        in_sequence_req, in_hops_in
//   result    out_valid (one-cycle)      out_action, out_fwd_source_id,
//                                        out_fwd_sequence, out_hops_out
//
// A header that fails the length or key check is answered in the cycle after it
// is accepted and the block stays ready. A header that passes is checked against
// the cache by one 48-bit comparator that walks the cache RAM one entry per cycle
// while busy stays high; a duplicate ends the walk at the matching entry. Reset
// (rst_n low, synchronous) empties the cache through per-entry valid bits, so no
// clearing pass is needed. The receiver cannot stall: every result is shown for
// one cycle.
module flood_relay_duplicate_filter #(
  parameter int CACHE_DEPTH = frdf_pkg::CACHE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [frdf_pkg::KEY_W-1:0]   cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_length_ok,
  input  logic [frdf_pkg::KEY_W-1:0]   in_packet_key,
  input  logic [frdf_pkg::SRC_W-1:0]   in_source_id,
  input  logic [frdf_pkg::SEQ_W-1:0]   in_sequence_req,
  input  logic [frdf_pkg::HOPS_W-1:0]  in_hops_in,
  output logic                         out_valid,
  output logic [frdf_pkg::ACT_W-1:0]   out_action,
  output logic [frdf_pkg::SRC_W-1:0]   out_fwd_source_id,
  output logic [frdf_pkg::SEQ_W-1:0]   out_fwd_sequence,
  output logic [frdf_pkg::HOPS_W-1:0]  out_hops_out
);

  import frdf_pkg::*;

  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);

  // Control state.
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       iss_idx_r, iss_idx_nxt;   // next cache entry to read
  logic                   iss_on_r, iss_on_nxt;     // reads still to be issued
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;   // entry whose data is on the RAM output
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       wp_r, wp_nxt;             // round-robin write pointer
  logic [CACHE_DEPTH-1:0] valid_r, valid_nxt;       // entries written since reset
  logic [KEY_W-1:0]       key_r, key_nxt;

  // Latched header of the transaction in progress.
  logic [SRC_W-1:0]       src_r, src_nxt;
  logic [SEQ_W-1:0]       seq_r, seq_nxt;
  logic [HOPS_W-1:0]      hops_r, hops_nxt;

  // Result registers.
  logic                   out_valid_r, out_valid_nxt;
  action_t                out_action_r, out_action_nxt;
  logic [SRC_W-1:0]       out_src_r, out_src_nxt;
  logic [SEQ_W-1:0]       out_seq_r, out_seq_nxt;
  logic [HOPS_W-1:0]      out_hops_r, out_hops_nxt;

  // Cache RAM interface.
  logic                   ram_we, ram_re;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata, entry_val;
  logic                   accept, pkt_ok, hit, last_cmp;

  frdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_cache (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(iss_idx_r),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign pkt_ok    = in_length_ok && (in_packet_key == key_r);
  assign ram_wdata = {src_r, seq_r};
  assign ram_re    = (state_r == S_SCAN) && iss_on_r;

  // An entry never written since reset reads as the all-zero pair.
  assign entry_val = valid_r[cmp_idx_r] ? ram_rdata : '0;
  assign hit       = cmp_vld_r && (entry_val == {src_r, seq_r});
  assign last_cmp  = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  always_comb begin
    state_nxt      = state_r;
    iss_idx_nxt    = iss_idx_r;
    iss_on_nxt     = iss_on_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    wp_nxt         = wp_r;
    valid_nxt      = valid_r;
    key_nxt        = key_r;
    src_nxt        = src_r;
    seq_nxt        = seq_r;
    hops_nxt       = hops_r;
    out_valid_nxt  = 1'b0;
    out_action_nxt = out_action_r;
    out_src_nxt    = out_src_r;
    out_seq_nxt    = out_seq_r;
    out_hops_nxt   = out_hops_r;
    ram_we         = 1'b0;

    if (cfg_we) begin
      key_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          src_nxt  = in_source_id;
          seq_nxt  = in_sequence_req;
          hops_nxt = in_hops_in;
          if (pkt_ok) begin
            state_nxt   = S_SCAN;
            iss_idx_nxt = '0;
            iss_on_nxt  = 1'b1;
          end else begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = ACT_INVALID;
            out_src_nxt    = '0;
            out_seq_nxt    = '0;
            out_hops_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // Seen before: drop and leave the cache untouched.
          state_nxt      = S_IDLE;
          iss_on_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_DUPLICATE;
          out_src_nxt    = '0;
          out_seq_nxt    = '0;
          out_hops_nxt   = '0;
        end else if (last_cmp) begin
          // Whole cache checked without a match: record the pair and forward.
          state_nxt            = S_IDLE;
          ram_we               = 1'b1;
          valid_nxt[wp_r]      = 1'b1;
          wp_nxt               = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
          out_valid_nxt        = 1'b1;
          out_action_nxt       = ACT_FORWARD;
          out_src_nxt          = src_r;
          out_seq_nxt          = seq_r;
          out_hops_nxt         = hops_r + 1'b1;
        end else begin
          cmp_vld_nxt = iss_on_r;
          cmp_idx_nxt = iss_idx_r;
          if (iss_on_r) begin
            if (iss_idx_r == LAST_IDX) begin
              iss_on_nxt = 1'b0;
            end else begin
              iss_idx_nxt = iss_idx_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        iss_on_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_idx_r   <= '0;
      iss_on_r    <= 1'b0;
      cmp_idx_r   <= '0;
      cmp_vld_r   <= 1'b0;
      wp_r        <= '0;
      valid_r     <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_idx_r   <= iss_idx_nxt;
      iss_on_r    <= iss_on_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      wp_r        <= wp_nxt;
      valid_r     <= valid_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    seq_r        <= seq_nxt;
    hops_r       <= hops_nxt;
    out_action_r <= out_action_nxt;
    out_src_r    <= out_src_nxt;
    out_seq_r    <= out_seq_nxt;
    out_hops_r   <= out_hops_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_fwd_source_id = out_src_r;
  assign out_fwd_sequence  = out_seq_r;
  assign out_hops_out      = out_hops_r;

endmodule
